FILE: sv/p2s_pkg.sv
`timescale 1ns / 1ps
package p2s_pkg;

  localparam int HISTORY_DEPTH = 8;
  localparam int SAMPLE_BITS   = 12;
  localparam int FULL_SCALE    = 1 << SAMPLE_BITS;

  localparam int SUM4_W      = SAMPLE_BITS + 2;
  localparam int OFFSET_W    = SAMPLE_BITS + 1;
  localparam int DIFF_W      = SAMPLE_BITS + 4;
  localparam int GAIN_W      = 10;
  localparam int GAIN_SHIFT  = 10;
  localparam int PROD_W      = SUM4_W + GAIN_W;
  localparam int STABLE_W    = 16;
  localparam int TOTAL_W     = SAMPLE_BITS + $clog2(HISTORY_DEPTH);
  localparam int STEP_CMP_W  = (TOTAL_W > STABLE_W) ? TOTAL_W : STABLE_W;
  localparam int SPEED_W     = SAMPLE_BITS + 1;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // drive thresholds, 0.02 (inclusive) and 0.03 (exclusive) of full scale
  localparam int REV_MIN = (2 * FULL_SCALE + 99) / 100;
  localparam int FWD_MIN = (3 * FULL_SCALE) / 100 + 1;

  localparam int LIMIT_RST      = 1638;
  localparam int POS_LOW_RST    = 1925;
  localparam int POS_HIGH_RST   = 2621;
  localparam int GAIN_FWD_RST   = 410;
  localparam int GAIN_REV_RST   = 512;
  localparam int STABLE_RST     = 1229;
  localparam int OFFSET_RST     = FULL_SCALE;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIMIT_FORWARD   = 3'd0,
    REG_LIMIT_REVERSE   = 3'd1,
    REG_POSITION_LOW    = 3'd2,
    REG_POSITION_HIGH   = 3'd3,
    REG_IGNORE_POSITION = 3'd4,
    REG_GAIN_FORWARD    = 3'd5,
    REG_GAIN_REVERSE    = 3'd6,
    REG_STABLE_LIMIT    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic ld2;
    logic ld3;
    logic ld4;
    logic capture;
  } p2s_ctl_t;

endpackage

FILE: sv/p2s_cell.sv
`timescale 1ns / 1ps
module p2s_cell
  import p2s_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   shift,
  input  logic [SAMPLE_BITS-1:0] sample_in,
  output logic [SAMPLE_BITS-1:0] sample_out,
  output logic [SAMPLE_BITS-1:0] step_out
);

  logic [SAMPLE_BITS-1:0] sample_r;
  logic [SAMPLE_BITS-1:0] step_r;
  logic [SAMPLE_BITS-1:0] step_nxt;

  // step to the older neighbour once the incoming sample takes this place
  assign step_nxt = (sample_in > sample_r) ? (sample_in - sample_r) : (sample_r - sample_in);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
      step_r   <= '0;
    end else if (shift) begin
      sample_r <= sample_in;
      step_r   <= step_nxt;
    end
  end

  assign sample_out = sample_r;
  assign step_out   = step_r;

endmodule

FILE: sv/p2s_window.sv
`timescale 1ns / 1ps
module p2s_window
  import p2s_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   shift,
  input  logic [SAMPLE_BITS-1:0] sample_in,
  output logic [SAMPLE_BITS-1:0] newest,
  output logic [SUM4_W-1:0]      sum4,
  output logic [TOTAL_W-1:0]     total
);

  logic [SAMPLE_BITS-1:0] cell_sample [HISTORY_DEPTH];
  logic [SAMPLE_BITS-1:0] cell_step   [HISTORY_DEPTH];
  logic [SAMPLE_BITS-1:0] chain_in    [HISTORY_DEPTH];
  logic [SAMPLE_BITS-1:0] head_step;
  logic [SUM4_W-1:0]      sum4_r;
  logic [SUM4_W-1:0]      sum4_nxt;
  logic [TOTAL_W-1:0]     all_r;
  logic [TOTAL_W-1:0]     all_nxt;

  assign chain_in[0] = sample_in;

  genvar g;
  generate
    for (g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
      if (g > 0) begin : g_link
        assign chain_in[g] = cell_sample[g-1];
      end
      p2s_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift      (shift),
        .sample_in  (chain_in[g]),
        .sample_out (cell_sample[g]),
        .step_out   (cell_step[g])
      );
    end
  endgenerate

  assign head_step = (sample_in > cell_sample[0]) ? (sample_in - cell_sample[0])
                                                  : (cell_sample[0] - sample_in);

  // running sums, the oldest cell's step lies outside the window
  assign sum4_nxt = sum4_r + SUM4_W'(sample_in) - SUM4_W'(cell_sample[3]);
  assign all_nxt  = all_r + TOTAL_W'(head_step) - TOTAL_W'(cell_step[HISTORY_DEPTH-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum4_r <= '0;
      all_r  <= '0;
    end else if (shift) begin
      sum4_r <= sum4_nxt;
      all_r  <= all_nxt;
    end
  end

  assign newest = cell_sample[0];
  assign sum4   = sum4_r;
  assign total  = all_r - TOTAL_W'(cell_step[HISTORY_DEPTH-1]);

endmodule

FILE: sv/p2s_drive.sv
`timescale 1ns / 1ps
module p2s_drive
  import p2s_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  p2s_ctl_t               ctl,
  input  logic [SUM4_W-1:0]      sum4_in,
  input  logic [SAMPLE_BITS-1:0] newest_in,
  input  logic [GAIN_W-1:0]      gain,
  input  logic [SAMPLE_BITS-1:0] limit,
  output logic [SAMPLE_BITS-1:0] drive
);

  logic [SUM4_W-1:0]        sum4_s2_r;
  logic [SAMPLE_BITS-1:0]   newest_s2_r;
  logic [OFFSET_W-1:0]      offset_r;
  logic signed [DIFF_W-1:0] diff;
  logic [SUM4_W-1:0]        d_nxt;
  logic [SUM4_W-1:0]        d_r;
  logic [PROD_W-1:0]        prod_r;
  logic [SUM4_W-1:0]        scaled;

  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      sum4_s2_r   <= sum4_in;
      newest_s2_r <= newest_in;
    end
    if (ctl.ld3) begin
      d_r <= d_nxt;
    end
    if (ctl.ld4) begin
      prod_r <= PROD_W'(d_r) * PROD_W'(gain);
    end
  end

  // offset seen by this request is the one before its own capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFFSET_W'(OFFSET_RST);
    end else if (ctl.capture) begin
      offset_r <= OFFSET_W'(newest_s2_r);
    end
  end

  assign diff  = $signed(DIFF_W'(sum4_s2_r)) - $signed(DIFF_W'({offset_r, 2'b00}));
  assign d_nxt = (diff > 0) ? diff[SUM4_W-1:0] : '0;

  assign scaled = prod_r[GAIN_SHIFT +: SUM4_W];
  assign drive  = (scaled > SUM4_W'(limit)) ? limit : scaled[SAMPLE_BITS-1:0];

endmodule

FILE: sv/pressure_to_speed_command.sv
`timescale 1ns / 1ps
// Takes one request per clock while in_stall is low and returns one result per request, in order;
// out_valid rises once the request has moved through stages s1 to s4 into the output register,
// and internal stages keep filling while a result waits.
// Each pressure channel is a row of sample cells that shift once per request and keep running
// sums for the four-sample mean and the step total used for the steadiness test. The offset
// subtract and the capture share one stage, so a capture takes effect from the very next request.
// Configuration is written through the cfg port, which is always ready; write it only while idle.
module pressure_to_speed_command
  import p2s_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [SAMPLE_BITS-1:0]    in_sample_forward,
  input  logic [SAMPLE_BITS-1:0]    in_sample_reverse,
  input  logic [SAMPLE_BITS-1:0]    in_position,
  input  logic                      in_mode,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [SPEED_W-1:0] out_speed,
  output logic                      out_offsets_captured,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  logic [SAMPLE_BITS-1:0] limit_forward_r;
  logic [SAMPLE_BITS-1:0] limit_reverse_r;
  logic [SAMPLE_BITS-1:0] position_low_r;
  logic [SAMPLE_BITS-1:0] position_high_r;
  logic                   ignore_position_r;
  logic [GAIN_W-1:0]      gain_forward_r;
  logic [GAIN_W-1:0]      gain_reverse_r;
  logic [STABLE_W-1:0]    stable_limit_r;

  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic free1, free2, free3, free4, free_out;
  logic accept, adv1, adv2, adv3, adv4;

  logic [SAMPLE_BITS-1:0] s1_pos_r, s2_pos_r, s3_pos_r, s4_pos_r;
  logic                   s1_mode_r, s2_mode_r;
  logic                   s2_steady_r;
  logic                   s3_captured_r, s4_captured_r;
  logic                   steady_nxt;

  logic [SAMPLE_BITS-1:0] newest_f, newest_rev;
  logic [SUM4_W-1:0]      sum4_f, sum4_rev;
  logic [TOTAL_W-1:0]     total_f, total_rev;
  logic [SAMPLE_BITS-1:0] drive_f, drive_rev;
  p2s_ctl_t               ctl;

  logic                      rev_ok, fwd_ok;
  logic signed [SPEED_W-1:0] speed_nxt;
  logic signed [SPEED_W-1:0] out_speed_r;
  logic                      out_captured_r;

  // handshake chain
  assign free_out = !out_v_r || !out_stall;
  assign adv4     = s4_v_r && free_out;
  assign free4    = !s4_v_r || free_out;
  assign adv3     = s3_v_r && free4;
  assign free3    = !s3_v_r || free4;
  assign adv2     = s2_v_r && free3;
  assign free2    = !s2_v_r || free3;
  assign adv1     = s1_v_r && free2;
  assign free1    = !s1_v_r || free2;
  assign accept   = in_valid && free1;
  assign in_stall = !free1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= accept || (s1_v_r && !adv1);
      s2_v_r  <= adv1 || (s2_v_r && !adv2);
      s3_v_r  <= adv2 || (s3_v_r && !adv3);
      s4_v_r  <= adv3 || (s4_v_r && !adv4);
      out_v_r <= adv4 || (out_v_r && !free_out);
    end
  end

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_forward_r   <= SAMPLE_BITS'(LIMIT_RST);
      limit_reverse_r   <= SAMPLE_BITS'(LIMIT_RST);
      position_low_r    <= SAMPLE_BITS'(POS_LOW_RST);
      position_high_r   <= SAMPLE_BITS'(POS_HIGH_RST);
      ignore_position_r <= 1'b0;
      gain_forward_r    <= GAIN_W'(GAIN_FWD_RST);
      gain_reverse_r    <= GAIN_W'(GAIN_REV_RST);
      stable_limit_r    <= STABLE_W'(STABLE_RST);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_LIMIT_FORWARD:   limit_forward_r   <= cfg_data[SAMPLE_BITS-1:0];
        REG_LIMIT_REVERSE:   limit_reverse_r   <= cfg_data[SAMPLE_BITS-1:0];
        REG_POSITION_LOW:    position_low_r    <= cfg_data[SAMPLE_BITS-1:0];
        REG_POSITION_HIGH:   position_high_r   <= cfg_data[SAMPLE_BITS-1:0];
        REG_IGNORE_POSITION: ignore_position_r <= cfg_data[0];
        REG_GAIN_FORWARD:    gain_forward_r    <= cfg_data[GAIN_W-1:0];
        REG_GAIN_REVERSE:    gain_reverse_r    <= cfg_data[GAIN_W-1:0];
        REG_STABLE_LIMIT:    stable_limit_r    <= cfg_data[STABLE_W-1:0];
        default: ;
      endcase
    end
  end

  // history windows
  p2s_window u_win_f (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift     (accept),
    .sample_in (in_sample_forward),
    .newest    (newest_f),
    .sum4      (sum4_f),
    .total     (total_f)
  );

  p2s_window u_win_r (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift     (accept),
    .sample_in (in_sample_reverse),
    .newest    (newest_rev),
    .sum4      (sum4_rev),
    .total     (total_rev)
  );

  assign steady_nxt = (STEP_CMP_W'(total_f) < STEP_CMP_W'(stable_limit_r)) &&
                      (STEP_CMP_W'(total_rev) < STEP_CMP_W'(stable_limit_r));

  assign ctl.ld2     = adv1;
  assign ctl.ld3     = adv2;
  assign ctl.ld4     = adv3;
  assign ctl.capture = adv2 && s2_mode_r && s2_steady_r;

  p2s_drive u_drv_f (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sum4_in   (sum4_f),
    .newest_in (newest_f),
    .gain      (gain_forward_r),
    .limit     (limit_forward_r),
    .drive     (drive_f)
  );

  p2s_drive u_drv_r (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sum4_in   (sum4_rev),
    .newest_in (newest_rev),
    .gain      (gain_reverse_r),
    .limit     (limit_reverse_r),
    .drive     (drive_rev)
  );

  // side payload through the stages
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos_r  <= in_position;
      s1_mode_r <= in_mode;
    end
    if (adv1) begin
      s2_pos_r    <= s1_pos_r;
      s2_mode_r   <= s1_mode_r;
      s2_steady_r <= steady_nxt;
    end
    if (adv2) begin
      s3_pos_r      <= s2_pos_r;
      s3_captured_r <= s2_mode_r && s2_steady_r;
    end
    if (adv3) begin
      s4_pos_r      <= s3_pos_r;
      s4_captured_r <= s3_captured_r;
    end
    if (adv4) begin
      out_speed_r    <= speed_nxt;
      out_captured_r <= s4_captured_r;
    end
  end

  // direction select, reverse first
  assign rev_ok = (drive_rev >= SAMPLE_BITS'(REV_MIN)) &&
                  (ignore_position_r || (s4_pos_r < position_high_r));
  assign fwd_ok = (drive_f >= SAMPLE_BITS'(FWD_MIN)) &&
                  (ignore_position_r || (s4_pos_r > position_low_r));

  always_comb begin
    if (rev_ok) begin
      speed_nxt = SPEED_W'(0) - $signed({1'b0, drive_rev});
    end else if (fwd_ok) begin
      speed_nxt = $signed({1'b0, drive_f});
    end else begin
      speed_nxt = '0;
    end
  end

  assign out_valid            = out_v_r;
  assign out_speed            = out_speed_r;
  assign out_offsets_captured = out_captured_r;

endmodule

FILE: sv/p2s_checker.sv
`timescale 1ns / 1ps
module p2s_checker
  import p2s_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [SPEED_W-1:0] out_speed,
  input logic                      out_offsets_captured,
  input logic                      cfg_valid,
  input logic                      cfg_ready
);

  // no request is held off while the output side is free
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled while output side free");

  // drive magnitude never reaches full scale
  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_speed != $signed({1'b1, {(SPEED_W-1){1'b0}}})))
    else $error("speed out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_speed) &&
                                  $stable(out_offsets_captured)))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

endmodule

bind pressure_to_speed_command p2s_checker u_p2s_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_speed            (out_speed),
  .out_offsets_captured (out_offsets_captured),
  .cfg_valid            (cfg_valid),
  .cfg_ready            (cfg_ready)
);

FILE: dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import p2s_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_LIMIT = 100;

  typedef struct packed {
    logic signed [SPEED_W-1:0] speed;
    logic                      captured;
  } speed_command_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [SAMPLE_BITS-1:0]    in_sample_forward = '0;
  logic [SAMPLE_BITS-1:0]    in_sample_reverse = '0;
  logic [SAMPLE_BITS-1:0]    in_position = '0;
  logic                      in_mode = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [SPEED_W-1:0] out_speed;
  logic                      out_offsets_captured;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  // predicted block state
  logic [11:0]            lim_fwd = 12'(LIMIT_RST);
  logic [11:0]            lim_rev = 12'(LIMIT_RST);
  logic [11:0]            pos_low = 12'(POS_LOW_RST);
  logic [11:0]            pos_high = 12'(POS_HIGH_RST);
  logic                   ignore_pos = 1'b0;
  logic [9:0]             gain_fwd = 10'(GAIN_FWD_RST);
  logic [9:0]             gain_rev = 10'(GAIN_REV_RST);
  logic [15:0]            stable_lim = 16'(STABLE_RST);
  logic [SAMPLE_BITS-1:0] hist_fwd [HISTORY_DEPTH] = '{default: '0};
  logic [SAMPLE_BITS-1:0] hist_rev [HISTORY_DEPTH] = '{default: '0};
  logic [OFFSET_W-1:0]    off_fwd = OFFSET_W'(OFFSET_RST);
  logic [OFFSET_W-1:0]    off_rev = OFFSET_W'(OFFSET_RST);

  speed_command_t pending_commands[$];
  speed_command_t expected_now;
  int samples_sent = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_hold = 0;

  pressure_to_speed_command dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_sample_forward    (in_sample_forward),
    .in_sample_reverse    (in_sample_reverse),
    .in_position          (in_position),
    .in_mode              (in_mode),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_speed            (out_speed),
    .out_offsets_captured (out_offsets_captured),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int channel_drive(input int sum4, input int offset, input int gain,
                                       input int lim);
    int v;
    if (sum4 <= offset * 4) return 0;
    v = ((sum4 - offset * 4) * gain) >>> GAIN_SHIFT;
    return (v > lim) ? lim : v;
  endfunction

  function automatic logic window_steady(input logic reverse_side);
    int total;
    int a;
    int b;
    total = 0;
    for (int i = 1; i < HISTORY_DEPTH; i++) begin
      a = int'(reverse_side ? hist_rev[i] : hist_fwd[i]);
      b = int'(reverse_side ? hist_rev[i-1] : hist_fwd[i-1]);
      total += (a > b) ? a - b : b - a;
    end
    return total < int'(stable_lim);
  endfunction

  function automatic speed_command_t compute_speed_command(input logic [11:0] sf, sr, pos,
                                                           input logic mode);
    speed_command_t res;
    int sum_f;
    int sum_r;
    int drv_f;
    int drv_r;
    res = '0;
    sum_f = 0;
    sum_r = 0;
    for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
      hist_fwd[i] = hist_fwd[i-1];
      hist_rev[i] = hist_rev[i-1];
    end
    hist_fwd[0] = sf;
    hist_rev[0] = sr;
    for (int i = 0; i < 4; i++) begin
      sum_f += int'(hist_fwd[i]);
      sum_r += int'(hist_rev[i]);
    end
    // offsets from before this request
    drv_f = channel_drive(sum_f, int'(off_fwd), int'(gain_fwd), int'(lim_fwd));
    drv_r = channel_drive(sum_r, int'(off_rev), int'(gain_rev), int'(lim_rev));
    if (drv_r * 100 >= 2 * FULL_SCALE && (ignore_pos || pos < pos_high)) begin
      res.speed = SPEED_W'(-drv_r);
    end else if (drv_f * 100 > 3 * FULL_SCALE && (ignore_pos || pos > pos_low)) begin
      res.speed = SPEED_W'(drv_f);
    end
    if (mode && window_steady(1'b0) && window_steady(1'b1)) begin
      off_fwd = {1'b0, hist_fwd[0]};
      off_rev = {1'b0, hist_rev[0]};
      res.captured = 1'b1;
    end
    return res;
  endfunction

  function automatic logic [11:0] clamp_sample(input int v);
    if (v < 0) return 12'd0;
    if (v > 4095) return 12'd4095;
    return 12'(v);
  endfunction

  function automatic logic [11:0] jitter(input int level, input int amp);
    return clamp_sample(level + int'($urandom_range(0, 2 * amp)) - amp);
  endfunction

  function automatic int pick_level(input logic reverse_side);
    int off;
    off = int'(reverse_side ? off_rev : off_fwd);
    case ($urandom_range(0, 4))
      0: return (off > 4095) ? 4095 : off;
      1: return 0;
      2: return 4095;
      default: return int'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [11:0] pick_position();
    case ($urandom_range(0, 6))
      0: return clamp_sample(int'(pos_low) + int'($urandom_range(0, 4)) - 2);
      1: return clamp_sample(int'(pos_high) + int'($urandom_range(0, 4)) - 2);
      2: return 12'd0;
      3: return 12'd4095;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic send_sample(input logic [11:0] sf, sr, pos, input logic mode);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_forward <= sf;
    in_sample_reverse <= sr;
    in_position <= pos;
    in_mode <= mode;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_commands.push_back(compute_speed_command(sf, sr, pos, mode));
    samples_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_commands.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_LIMIT_FORWARD:   lim_fwd = value[11:0];
      REG_LIMIT_REVERSE:   lim_rev = value[11:0];
      REG_POSITION_LOW:    pos_low = value[11:0];
      REG_POSITION_HIGH:   pos_high = value[11:0];
      REG_IGNORE_POSITION: ignore_pos = value[0];
      REG_GAIN_FORWARD:    gain_fwd = value[9:0];
      REG_GAIN_REVERSE:    gain_rev = value[9:0];
      REG_STABLE_LIMIT:    stable_lim = value;
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [15:0] lf, lr, pl, ph, ig, gf, gr, st);
    drain_results();
    write_reg(REG_LIMIT_FORWARD, lf);
    write_reg(REG_LIMIT_REVERSE, lr);
    write_reg(REG_POSITION_LOW, pl);
    write_reg(REG_POSITION_HIGH, ph);
    write_reg(REG_IGNORE_POSITION, ig);
    write_reg(REG_GAIN_FORWARD, gf);
    write_reg(REG_GAIN_REVERSE, gr);
    write_reg(REG_STABLE_LIMIT, st);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_random_settings();
    logic [15:0] st;
    case ($urandom_range(0, 3))
      0: st = 16'($urandom_range(0, 65535));
      1: st = 16'($urandom_range(200, 3000));
      2: st = 16'hFFFF;
      default: st = 16'(STABLE_RST);
    endcase
    load_settings(16'($urandom_range(0, 4095)), 16'($urandom_range(0, 4095)),
                  16'($urandom_range(0, 4095)), 16'($urandom_range(0, 4095)),
                  16'($urandom_range(0, 1)), 16'($urandom_range(0, 1023)),
                  16'($urandom_range(0, 1023)), st);
  endtask

  // mostly steady runs so that captures happen, with noise and spiked runs mixed in
  task automatic send_run();
    int kind;
    int len;
    int amp;
    int lvl_f;
    int lvl_r;
    kind = int'($urandom_range(0, 9));
    if (kind >= 7) begin
      len = int'($urandom_range(1, 6));
      repeat (len) begin
        send_sample(12'($urandom), 12'($urandom), pick_position(), 1'($urandom));
      end
    end else begin
      len = int'($urandom_range(4, 16));
      case ($urandom_range(0, 4))
        0: amp = 0;
        1: amp = 2;
        2: amp = 20;
        3: amp = 150;
        default: amp = 600;
      endcase
      lvl_f = pick_level(1'b0);
      lvl_r = pick_level(1'b1);
      repeat (len) begin
        send_sample(jitter(lvl_f, amp), jitter(lvl_r, amp), pick_position(),
                    $urandom_range(0, 3) != 0);
      end
      if (kind == 6) begin
        send_sample(12'($urandom), 12'($urandom), pick_position(), 1'b1);
      end
    end
  endtask

  task automatic run_items(input int count);
    int start;
    start = samples_sent;
    while (samples_sent - start < count) send_run();
  endtask

  task automatic test_directed_extremes();
    send_sample(12'd0, 12'd0, 12'd0, 1'b0);
    send_sample(12'd4095, 12'd4095, 12'd4095, 1'b1);
    repeat (7) send_sample(12'd0, 12'd0, 12'd2000, 1'b0);
    // window clear of the spike, offsets drop to zero
    send_sample(12'd0, 12'd0, 12'd2000, 1'b1);
    send_sample(12'd0, 12'd0, 12'd2000, 1'b0);
    send_sample(12'd4095, 12'd0, 12'd4095, 1'b0);
    send_sample(12'd0, 12'd4095, 12'd0, 1'b0);
    send_sample(12'd0, 12'd4095, 12'(POS_HIGH_RST), 1'b0);
    send_sample(12'd4095, 12'd0, 12'(POS_LOW_RST), 1'b0);
    send_sample(12'd2048, 12'd2048, 12'd3000, 1'b1);
    send_sample(12'd1, 12'd1, 12'(POS_LOW_RST + 1), 1'b1);
    send_sample(12'hAAA, 12'h555, 12'hAAA, 1'b0);
    send_sample(12'h555, 12'hAAA, 12'h555, 1'b1);
  endtask

  task automatic test_register_settings();
    load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_items(40);
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  16'hFFFF);
    run_items(40);
    load_settings(16'd4095, 16'd4095, 16'd0, 16'd4095, 16'd0, 16'd1023, 16'd1023, 16'd65535);
    run_items(40);
    load_settings(16'(LIMIT_RST), 16'(LIMIT_RST), 16'(POS_LOW_RST), 16'(POS_HIGH_RST), 16'd0,
                  16'(GAIN_FWD_RST), 16'(GAIN_REV_RST), 16'(STABLE_RST));
    run_items(40);
    repeat (2) begin
      load_random_settings();
      run_items(40);
    end
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 70;
    recv_idle_pct = 9;
    repeat (4) begin
      load_random_settings();
      run_items(100);
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (3) begin
      load_random_settings();
      run_items(100);
    end
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_hold = 400;
    run_items(60);
  endtask

  always @(posedge clk) begin
    if (stall_hold > 0) begin
      out_stall <= 1'b1;
      stall_hold = stall_hold - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_commands.size() == 0) begin
        report_mismatch("unrequested speed", int'(out_speed), 0);
      end else begin
        expected_now = pending_commands.pop_front();
        if (out_speed !== expected_now.speed) begin
          report_mismatch("speed", int'(out_speed), int'($signed(expected_now.speed)));
        end
        if (out_offsets_captured !== expected_now.captured) begin
          report_mismatch("offsets_captured", int'(out_offsets_captured),
                          int'(expected_now.captured));
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("pressure_to_speed_command verification failed");
    $finish;
  end

  initial begin
    send_idle_pct = 9;
    recv_idle_pct = 70;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_extremes();
    test_register_settings();
    test_random_traffic();
    test_output_backpressure();
    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("pressure_to_speed_command verification clean");
    end else begin
      $display("pressure_to_speed_command verification failed");
    end
    $finish;
  end

endmodule

FILE: pressure_to_speed_command.f
sv/p2s_pkg.sv
sv/p2s_cell.sv
sv/p2s_window.sv
sv/p2s_drive.sv
sv/pressure_to_speed_command.sv
sv/p2s_checker.sv
dv/testbench.sv
